>>> hdl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared codes, widths and types for the LRU page replacement unit.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  // Configuration port geometry.
  localparam int PADDR_W    = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CAP_W      = 5;

  // Word select (paddr bit 2) of the capacity register.
  localparam logic REG_CAPACITY = 1'b0;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation carried by an item.
  typedef enum logic {
    OP_ACCESS = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  // Result code of an item.
  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_REPLACED  = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Result of one table update.
  typedef struct packed {
    status_t status;
    logic    evicted;
  } tbl_result_t;

endpackage

>>> hdl/lrupr_cfg.sv
// ----------------------------------------------------------------------------
// LRU page replacement configuration register
// APB-style register port holding the capacity limit, with the limit clamped
// into the range that the table supports.
// ----------------------------------------------------------------------------
module lrupr_cfg #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lrupr_pkg::PADDR_W-1:0]   paddr,
  input  logic [lrupr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lrupr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [$clog2(MAX_ENTRIES+1)-1:0] cap_limit
);
  import lrupr_pkg::*;

  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CMPW-1:0] MAX_W = CMPW'(MAX_ENTRIES);
  localparam logic [CMPW-1:0] ONE_W = CMPW'(1);

  logic [CAP_W-1:0] capacity;
  logic [CMPW-1:0]  cap_wide;
  logic [CMPW-1:0]  cap_clamped;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (wr_en) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = CFG_DATA_W'(capacity);
    end
  end

  // Zero acts as one, and anything above the table size acts as the table size.
  always_comb begin
    cap_wide = CMPW'(capacity);
    if (cap_wide == '0) begin
      cap_clamped = ONE_W;
    end else if (cap_wide > MAX_W) begin
      cap_clamped = MAX_W;
    end else begin
      cap_clamped = cap_wide;
    end
  end

  assign cap_limit = cap_clamped[CW-1:0];

endmodule

>>> hdl/lrupr_table.sv
// ----------------------------------------------------------------------------
// LRU page replacement table
// Fully associative address table with a recency rank per entry. One item is
// looked up and the table updated in a single pass.
// ----------------------------------------------------------------------------
module lrupr_table #(
  parameter int MAX_ENTRIES  = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  lrupr_pkg::opcode_t               op,
  input  logic [ADDRESS_BITS-1:0]          addr,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0] cap_limit,
  output lrupr_pkg::tbl_result_t           result,
  output logic [ADDRESS_BITS-1:0]          victim
);
  import lrupr_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [ADDRESS_BITS-1:0] entry_address [MAX_ENTRIES];
  logic [RW-1:0]           entry_age_rank [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  entry_valid;
  logic [CW-1:0]           occupied_count;

  logic [MAX_ENTRIES-1:0]  match;
  logic [MAX_ENTRIES-1:0]  free_oh;
  logic [MAX_ENTRIES-1:0]  old_oh;
  logic [MAX_ENTRIES-1:0]  sel;
  logic [MAX_ENTRIES:0]    all_below;
  logic [RW-1:0]           hit_rank;
  logic [RW-1:0]           last_rank;
  logic [ADDRESS_BITS-1:0] old_addr;
  logic                    hit;
  logic                    room;
  logic                    is_remove;

  assign is_remove = (op == OP_REMOVE);
  assign hit       = |match;
  assign room      = occupied_count < cap_limit;
  assign last_rank = RW'(occupied_count - CW'(1));
  assign all_below[0] = 1'b1;

  // Per-entry compare, first free slot and least recent slot.
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_match
    assign match[k]         = entry_valid[k] && (entry_address[k] == addr);
    assign all_below[k + 1] = all_below[k] && entry_valid[k];
    assign free_oh[k]       = !entry_valid[k] && all_below[k];
    assign old_oh[k]        = entry_valid[k] && (entry_age_rank[k] == last_rank);
    assign sel[k]           = hit ? match[k] : (room ? free_oh[k] : old_oh[k]);
  end

  // Rank of the hit entry and address of the least recent entry.
  always_comb begin
    hit_rank = '0;
    old_addr = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (match[k]) begin
        hit_rank = hit_rank | entry_age_rank[k];
      end
      if (old_oh[k]) begin
        old_addr = old_addr | entry_address[k];
      end
    end
  end

  // Result of the item.
  always_comb begin
    result.evicted = 1'b0;
    if (is_remove) begin
      result.status = hit ? ST_REMOVED : ST_NOT_FOUND;
    end else if (hit) begin
      result.status = ST_HIT;
    end else if (room) begin
      result.status = ST_INSERTED;
    end else begin
      result.status  = ST_REPLACED;
      result.evicted = 1'b1;
    end
  end

  assign victim = result.evicted ? old_addr : '0;

  // Per-entry state update.
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_entry
    always_ff @(posedge clk) begin
      if (rst) begin
        entry_valid[k]    <= 1'b0;
        entry_age_rank[k] <= '0;
      end else if (go) begin
        if (is_remove) begin
          // Removal closes the gap the entry leaves in the order.
          if (match[k]) begin
            entry_valid[k]    <= 1'b0;
            entry_age_rank[k] <= '0;
          end else if (entry_valid[k] && hit && entry_age_rank[k] > hit_rank) begin
            entry_age_rank[k] <= entry_age_rank[k] - RW'(1);
          end
        end else if (sel[k]) begin
          entry_valid[k]    <= 1'b1;
          entry_age_rank[k] <= '0;
        end else if (entry_valid[k] && (!hit || entry_age_rank[k] < hit_rank)) begin
          entry_age_rank[k] <= entry_age_rank[k] + RW'(1);
        end
      end
    end

    // Address store: written on insert or replace only.
    always_ff @(posedge clk) begin
      if (go && !is_remove && !hit && sel[k]) begin
        entry_address[k] <= addr;
      end
    end
  end

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied_count <= '0;
    end else if (go) begin
      if (is_remove && hit) begin
        occupied_count <= occupied_count - CW'(1);
      end else if (!is_remove && !hit && room) begin
        occupied_count <= occupied_count + CW'(1);
      end
    end
  end

  // The count always matches the number of valid entries.
  assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(occupied_count))
    else $error("occupancy count differs from valid entries");

  // A stored address is never held twice.
  assert property (@(posedge clk) disable iff (rst) $onehot0(match))
    else $error("address matches more than one entry");

  // A full table always has exactly one least recent entry to evict.
  assert property (@(posedge clk) disable iff (rst)
    (go && !is_remove && !hit && !room) |-> $onehot(old_oh))
    else $error("no unique least recent entry on replacement");

  // An insert grows the table by one.
  assert property (@(posedge clk) disable iff (rst)
    (go && result.status == ST_INSERTED) |=> occupied_count == $past(occupied_count) + CW'(1))
    else $error("insert did not grow the occupancy");

endmodule

>>> hdl/lru_page_replacement_unit.sv
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Fully associative LRU tracker of page addresses with a programmable
// capacity; reports hit, insert, replace with victim, or remove.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, its result in the result register.
// Throughput: one item per cycle while out_stall is low; the table lookup and rank
//   update for an item complete in one pass between the two registers.
// Reset: the table is empty and the capacity register reads 16.
module lru_page_replacement_unit #(
  parameter int MAX_ENTRIES  = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             opcode,
  input  logic [ADDRESS_BITS-1:0]          page_address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       status,
  output logic [ADDRESS_BITS-1:0]          victim_address,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lrupr_pkg::PADDR_W-1:0]    paddr,
  input  logic [lrupr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lrupr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import lrupr_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic                    s1_valid;
  opcode_t                 s1_op;
  logic [ADDRESS_BITS-1:0] s1_addr;
  logic                    advance;
  logic                    go;
  logic                    accept;
  logic [CW-1:0]           cap_limit;
  tbl_result_t             tbl_res;
  logic [ADDRESS_BITS-1:0] tbl_victim;

  // Handshake: the result register frees when empty or taken.
  assign advance  = !out_valid || !out_stall;
  assign go       = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= opcode_t'(opcode);
      s1_addr <= page_address;
    end
  end

  lrupr_cfg #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cap_limit (cap_limit)
  );

  lrupr_table #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .op        (s1_op),
    .addr      (s1_addr),
    .cap_limit (cap_limit),
    .result    (tbl_res),
    .victim    (tbl_victim)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      status         <= tbl_res.status;
      victim_address <= tbl_victim;
    end
  end

endmodule
